// ===== sv/base64_stream_encoder_assert.svh =====
// Assertion macros for the base64 stream encoder.
// Used by the top level only; compiled away when SYNTH is defined.
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH
`ifndef SYNTH
// expression must hold at every clock edge out of reset
`define B64_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("base64 encoder check failed");
// antecedent implies consequent in the same cycle
`define B64_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("base64 encoder check failed");
`else
`define B64_ASSERT(lbl, clk, rstn, expr)
`define B64_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/b64_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 encoder.
// No dependencies.
`timescale 1ns / 1ps

package b64_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CAP_WIDTH   = 16;
    localparam int SUM_WIDTH   = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 1;

    localparam logic [SUM_WIDTH-1:0] CNT_MAX =
        SUM_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [SUM_WIDTH-1:0] NEED_GROUP = SUM_WIDTH'(4);
    localparam logic [SUM_WIDTH-1:0] NEED_LAST  = SUM_WIDTH'(5);
    localparam logic [COUNT_WIDTH-1:0] CHARS_PER_GROUP = COUNT_WIDTH'(4);

    localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(65535);

    localparam logic [7:0] PAD_CHAR      = 8'h3D;
    localparam logic [7:0] ERR_CHAR      = 8'h00;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_PLUS    = 8'h2B;
    localparam logic [7:0] ASCII_SLASH   = 8'h2F;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam logic [1:0] LAST_SLOT = 2'd3;

    // one encoded group, or an error marker
    typedef struct packed {
        logic [23:0] group;
        logic [1:0]  valid;     // data bytes in the group, 1 to 3
        logic        last;
        logic        err;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] idx8;
        idx8 = {2'b00, idx};
        if (idx < 6'd26)
            return 8'(ASCII_UPPER_A + idx8);
        else if (idx < 6'd52)
            return 8'(ASCII_LOWER_A + idx8 - 8'd26);
        else if (idx < 6'd62)
            return 8'(ASCII_ZERO + idx8 - 8'd52);
        else if (idx == 6'd62)
            return ASCII_PLUS;
        else
            return ASCII_SLASH;
    endfunction

endpackage

// ===== sv/b64_front.sv =====
// Front end: takes bytes, builds 24-bit groups, checks output capacity
// and queues one request per group or error. Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_front
    import b64_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CAP_WIDTH-1:0] cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  q_status_t            q_status,
    output logic                 push,
    output cmd_t                 push_cmd
);

    logic [CAP_WIDTH-1:0]   cap_reg,     cap_next;
    logic [15:0]            held_reg,    held_next;
    logic [1:0]             pos_reg,     pos_next;
    logic [COUNT_WIDTH-1:0] cw_reg,      cw_next;
    logic                   aborted_reg, aborted_next;

    logic                 accept;
    logic                 emit;
    logic                 ovf;
    logic [SUM_WIDTH-1:0] sum;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    // third byte or last marker closes a group
    assign emit     = !aborted_reg && (pos_reg[1] || in_last);
    assign push     = accept && emit;

    assign sum = SUM_WIDTH'(cw_reg) + (in_last ? NEED_LAST : NEED_GROUP);
    assign ovf = (sum > SUM_WIDTH'(cap_reg)) || (sum > CNT_MAX);

    always_comb
    begin
        case (pos_reg)
            2'd0:    push_cmd.group = {in_byte, 16'h0000};
            2'd1:    push_cmd.group = {held_reg[7:0], in_byte, 8'h00};
            default: push_cmd.group = {held_reg, in_byte};
        endcase
        case (pos_reg)
            2'd0:    push_cmd.valid = 2'd1;
            2'd1:    push_cmd.valid = 2'd2;
            default: push_cmd.valid = 2'd3;
        endcase
        push_cmd.last = in_last;
        push_cmd.err  = ovf;
    end

    always_comb
    begin
        cap_next     = cfg_wr_en ? cfg_wr_data : cap_reg;
        held_next    = held_reg;
        pos_next     = pos_reg;
        cw_next      = cw_reg;
        aborted_next = aborted_reg;
        if (accept)
        begin
            if (aborted_reg)
            begin
                if (in_last)
                begin
                    aborted_next = 1'b0;
                    held_next    = '0;
                    pos_next     = '0;
                    cw_next      = '0;
                end
            end
            else if (!emit)
            begin
                held_next = {held_reg[7:0], in_byte};
                pos_next  = 2'(pos_reg + 2'd1);
            end
            else
            begin
                held_next = '0;
                pos_next  = '0;
                if (ovf)
                begin
                    cw_next      = '0;
                    aborted_next = !in_last;
                end
                else if (in_last)
                    cw_next = '0;
                else
                    cw_next = COUNT_WIDTH'(cw_reg + CHARS_PER_GROUP);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= CAP_RESET;
            held_reg    <= '0;
            pos_reg     <= '0;
            cw_reg      <= '0;
            aborted_reg <= 1'b0;
        end
        else
        begin
            cap_reg     <= cap_next;
            held_reg    <= held_next;
            pos_reg     <= pos_next;
            cw_reg      <= cw_next;
            aborted_reg <= aborted_next;
        end
    end

endmodule

// ===== sv/b64_cmd_queue.sv =====
// Two-entry queue of group requests between front and back end.
// Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_cmd_queue
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t status
);

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg,  count_next;

    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = Q_CNT_W'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = Q_CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== sv/b64_back.sv =====
// Back end: walks the queue head one character per cycle, while the output
// is not stalled, into the output register. Depends on b64_pkg.
`timescale 1ns / 1ps

module b64_back
    import b64_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      head,
    input  q_status_t q_status,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [7:0] out_char,
    output logic      out_err,
    output logic      out_end
);

    logic [1:0] slot_reg, slot_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       err_reg,  err_next;
    logic       end_reg,  end_next;

    logic       load;
    logic [5:0] sextet;

    assign load = !q_status.empty && (!valid_reg || out_ready);
    assign pop  = load && (head.err || slot_reg == LAST_SLOT);

    always_comb
    begin
        case (slot_reg)
            2'd0:    sextet = head.group[23:18];
            2'd1:    sextet = head.group[17:12];
            2'd2:    sextet = head.group[11:6];
            default: sextet = head.group[5:0];
        endcase
    end

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        err_next   = err_reg;
        end_next   = end_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (head.err)
            begin
                char_next = ERR_CHAR;
                err_next  = 1'b1;
                end_next  = 1'b1;
            end
            else
            begin
                // slot beyond the data bytes is padding
                char_next = (slot_reg <= head.valid) ? b64_char(sextet) : PAD_CHAR;
                err_next  = 1'b0;
                end_next  = head.last && (slot_reg == LAST_SLOT);
            end
            slot_next = pop ? 2'd0 : 2'(slot_reg + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        err_reg  <= err_next;
        end_reg  <= end_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_err   = err_reg;
    assign out_end   = end_reg;

endmodule

// ===== sv/base64_stream_encoder.sv =====
// Streaming base64 encoder, standard alphabet with '=' padding. Bytes enter
// one per cycle while the two-entry group queue has room; every third byte,
// or the byte marked last, closes a group that leaves as four characters, one
// per cycle while the output is not stalled, from the output register through
// the single character port of the back end. output_capacity counts
// characters per message plus one terminator slot (never sent); a group that
// would not fit gives one error result (char 0, tuser high, tlast high) and
// the rest of the message is dropped up to its last byte.
`timescale 1ns / 1ps
`include "base64_stream_encoder_assert.svh"

module base64_stream_encoder
    import b64_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CAP_WIDTH-1:0] cfg_wr_data,   // output_capacity
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
    input  logic                 s_axis_tlast,  // last_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // [7:0] out_char
    output logic                 m_axis_tuser,  // [0] overflow_error
    output logic                 m_axis_tlast   // end_of_message
);

    cmd_t      push_cmd;
    cmd_t      head;
    q_status_t q_status;
    logic      push;
    logic      pop;

    b64_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    b64_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_err   (m_axis_tuser),
        .out_end   (m_axis_tlast)
    );

    `B64_ASSERT(a_q_consistent, clk, rst_n, !(q_status.full && q_status.empty))
    `B64_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !q_status.full)
    `B64_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !q_status.empty)
    `B64_ASSERT_IMP(a_err_result, clk, rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tlast && (m_axis_tdata == ERR_CHAR))

endmodule
